>>> rtl/lhp_pkg.sv
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared beat types, command/status bundles and arithmetic constants for the
// latency histogram with nearest-rank percentile query.
// ----------------------------------------------------------------------------
package lhp_pkg;

  // field widths
  localparam int LAT_W = 40;
  localparam int Q_W   = 17;
  localparam int PCT_W = 10;
  localparam int CNT_W = 32;

  // command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // ns -> us ceiling divide: floor((x + 999) * RECIP >> 36) for x below 2^26
  localparam int              NS_PER_US   = 1000;
  localparam int              ROUND_ADD   = NS_PER_US - 1;
  localparam int              DIV_X_W     = 26;
  localparam int              RECIP_W     = 27;
  localparam int              RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP    = 27'd68719477;

  // Q16 quantile
  localparam int             Q_FRAC = 16;
  localparam logic [Q_W-1:0] Q_ONE  = 17'd65536;
  localparam logic [Q_FRAC-1:0] Q_RND = 16'hFFFF;

  // input beat
  typedef struct packed {
    logic             command;
    logic [LAT_W-1:0] latency_ns;
    logic [Q_W-1:0]   quantile;
  } lhp_in_t;

  // result beat
  typedef struct packed {
    logic [PCT_W-1:0] percentile_us;
    logic [CNT_W-1:0] sample_count;
    logic [CNT_W-1:0] ovf_count;
  } lhp_out_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;
    logic clr_we;
    logic rec_mul;
    logic rec_rd;
    logic rec_wr;
    logic q_mul;
    logic q_rank;
    logic walk;
    logic emit;
  } lhp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic walk_done;
  } lhp_sts_t;

endpackage

>>> rtl/lhp_ctrl.sv
// ----------------------------------------------------------------------------
// lhp_ctrl
// Sequencer for the histogram: clearing pass after reset, record
// read-modify-write, and the query rank computation and bin walk.
// ----------------------------------------------------------------------------
module lhp_ctrl import lhp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_command,
  input  lhp_sts_t sts,
  output lhp_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b0_0000_0001,
    S_IDLE    = 9'b0_0000_0010,
    S_REC_MUL = 9'b0_0000_0100,
    S_REC_RD  = 9'b0_0000_1000,
    S_REC_WR  = 9'b0_0001_0000,
    S_Q_MUL   = 9'b0_0010_0000,
    S_Q_RANK  = 9'b0_0100_0000,
    S_Q_WALK  = 9'b0_1000_0000,
    S_Q_EMIT  = 9'b1_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = (in_command == CMD_QUERY) ? S_Q_MUL : S_REC_MUL;
      end
      S_REC_MUL: state_nxt = S_REC_RD;
      S_REC_RD:  state_nxt = S_REC_WR;
      S_REC_WR:  state_nxt = S_IDLE;
      S_Q_MUL:   state_nxt = S_Q_RANK;
      S_Q_RANK:  state_nxt = S_Q_WALK;
      S_Q_WALK: begin
        if (sts.walk_done) state_nxt = S_Q_EMIT;
      end
      S_Q_EMIT:  state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd         = '0;
    cmd.cap     = (state_r == S_IDLE) && start;
    cmd.clr_we  = (state_r == S_CLEAR);
    cmd.rec_mul = (state_r == S_REC_MUL);
    cmd.rec_rd  = (state_r == S_REC_RD);
    cmd.rec_wr  = (state_r == S_REC_WR);
    cmd.q_mul   = (state_r == S_Q_MUL);
    cmd.q_rank  = (state_r == S_Q_RANK);
    cmd.walk    = (state_r == S_Q_WALK);
    cmd.emit    = (state_r == S_Q_EMIT);
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/lhp_dp.sv
// ----------------------------------------------------------------------------
// lhp_dp
// Histogram datapath: bin memory, sample and overflow counters, the
// ns-to-us converter, the rank multiplier and the running-sum bin walk.
// ----------------------------------------------------------------------------
module lhp_dp import lhp_pkg::*; #(
  parameter int MAX_BIN_US = 1023
) (
  input  logic     clk,
  input  logic     rst_n,
  input  lhp_in_t  in_data,
  input  lhp_cmd_t cmd,
  output lhp_sts_t sts,
  output lhp_out_t out_data
);

  localparam int NUM_BINS = MAX_BIN_US + 1;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int UP_W     = DIV_X_W + RECIP_W;
  localparam int QP_W     = Q_W + CNT_W;
  localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(MAX_BIN_US);
  // rounded us reaches the last bin exactly when ns exceeds this
  localparam logic [LAT_W-1:0] OVF_LIMIT =
    LAT_W'(64'(NS_PER_US) * 64'(MAX_BIN_US - 1));

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  logic [CNT_W-1:0] bin_mem [NUM_BINS];
  logic [CNT_W-1:0] rdata_r;

  lhp_in_t          in_r;
  logic [UP_W-1:0]  us_prod_r;
  logic             ovf_r;
  logic [BIN_W-1:0] bin_idx_r;
  logic [QP_W-1:0]  q_prod_r;
  logic [CNT_W-1:0] rank_r;
  logic [BIN_W-1:0] pct_r;
  logic [BIN_W-1:0] cmp_idx_r;

  logic [CNT_W-1:0] total_r,    total_nxt;
  logic [CNT_W-1:0] ovf_cnt_r,  ovf_cnt_nxt;
  logic [BIN_W-1:0] clr_idx_r,  clr_idx_nxt;
  logic [BIN_W-1:0] walk_idx_r, walk_idx_nxt;
  logic             rd_vld_r,   rd_vld_nxt;
  logic [CNT_W:0]   run_r,      run_nxt;

  logic [DIV_X_W-1:0] us_x;
  logic [BIN_W-1:0]   bin_sel;
  logic [Q_W-1:0]     q_sat;
  logic [QP_W:0]      rank_sum;
  logic [CNT_W:0]     walk_sum;
  logic               walk_hit;
  logic               rd_en, wr_en;
  logic [BIN_W-1:0]   rd_addr, wr_addr;
  logic [CNT_W-1:0]   wr_data;

  // ns -> us conversion and bin selection
  assign us_x    = in_r.latency_ns[DIV_X_W-1:0] + DIV_X_W'(ROUND_ADD);
  assign bin_sel = ovf_r ? LAST_BIN : us_prod_r[RECIP_SHIFT +: BIN_W];

  // quantile clamp and rank rounding
  assign q_sat    = (in_r.quantile > Q_ONE) ? Q_ONE : in_r.quantile;
  assign rank_sum = (QP_W+1)'(q_prod_r) + (QP_W+1)'(Q_RND);

  // running-sum compare for the walk
  assign walk_sum = run_r + (CNT_W+1)'(rdata_r);
  assign walk_hit = (walk_sum >= (CNT_W+1)'(rank_r)) || (cmp_idx_r == LAST_BIN);

  assign sts.walk_done = cmd.walk && rd_vld_r && walk_hit;
  assign sts.clr_last  = cmd.clr_we && (clr_idx_r == LAST_BIN);

  // memory port steering
  assign rd_en   = cmd.rec_rd || cmd.walk;
  assign rd_addr = cmd.rec_rd ? bin_sel : walk_idx_r;
  assign wr_en   = cmd.clr_we || cmd.rec_wr;
  assign wr_addr = cmd.clr_we ? clr_idx_r : bin_idx_r;
  assign wr_data = cmd.clr_we ? '0 : sat_inc(rdata_r);

  always_ff @(posedge clk) begin
    if (wr_en) bin_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= bin_mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) in_r <= in_data;
    if (cmd.rec_mul) begin
      ovf_r     <= (in_r.latency_ns > OVF_LIMIT);
      us_prod_r <= UP_W'(us_x) * UP_W'(RECIP);
    end
    if (cmd.rec_rd) bin_idx_r <= bin_sel;
    if (cmd.q_mul)  q_prod_r  <= QP_W'(q_sat) * QP_W'(total_r);
    if (cmd.q_rank) rank_r    <= rank_sum[Q_FRAC +: CNT_W];
    if (cmd.walk)   cmp_idx_r <= walk_idx_r;
    if (sts.walk_done) pct_r  <= cmp_idx_r;
  end

  // counters and walk control
  always_comb begin
    total_nxt    = total_r;
    ovf_cnt_nxt  = ovf_cnt_r;
    clr_idx_nxt  = clr_idx_r;
    walk_idx_nxt = walk_idx_r;
    rd_vld_nxt   = rd_vld_r;
    run_nxt      = run_r;
    if (cmd.clr_we && (clr_idx_r != LAST_BIN)) clr_idx_nxt = clr_idx_r + 1'b1;
    if (cmd.rec_wr) begin
      total_nxt = sat_inc(total_r);
      if (ovf_r) ovf_cnt_nxt = sat_inc(ovf_cnt_r);
    end
    if (cmd.q_rank) begin
      walk_idx_nxt = '0;
      rd_vld_nxt   = 1'b0;
      run_nxt      = '0;
    end
    if (cmd.walk) begin
      rd_vld_nxt = 1'b1;
      if (walk_idx_r != LAST_BIN) walk_idx_nxt = walk_idx_r + 1'b1;
      if (rd_vld_r) run_nxt = walk_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      ovf_cnt_r  <= '0;
      clr_idx_r  <= '0;
      walk_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      run_r      <= '0;
    end else begin
      total_r    <= total_nxt;
      ovf_cnt_r  <= ovf_cnt_nxt;
      clr_idx_r  <= clr_idx_nxt;
      walk_idx_r <= walk_idx_nxt;
      rd_vld_r   <= rd_vld_nxt;
      run_r      <= run_nxt;
    end
  end

  // result beat
  assign out_data.percentile_us = PCT_W'(pct_r);
  assign out_data.sample_count  = total_r;
  assign out_data.ovf_count     = ovf_cnt_r;

endmodule

>>> rtl/latency_histogram_percentile.sv
// ----------------------------------------------------------------------------
// latency_histogram_percentile
// Microsecond latency histogram with a nearest-rank percentile query.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data and raise start; the beat is taken at an edge where busy is
//   low. command 0 records latency_ns (rounded up to whole us, clamped to
//   bin MAX_BIN_US); command 1 queries the bin at quantile (Q16).
//   A query returns one beat on out_data, marked by out_valid for a single
//   cycle; the receiver cannot stall it. A record returns nothing.
// Sequence:
//   Record: busy after accept through multiply, bin read and bin write;
//   a new beat is not taken until the record is through.
//   Query: after accept, rank multiply and rank rounding, then the walk
//   reads one bin per cycle from the bin memory up to the reported bin;
//   out_valid follows the walk, and busy drops the cycle after out_valid.
// Reset:
//   rst_n (synchronous) zeroes both counters and starts a clearing pass over
//   all MAX_BIN_US + 1 bins of the bin memory; busy stays high meanwhile.
// ----------------------------------------------------------------------------
module latency_histogram_percentile import lhp_pkg::*; #(
  parameter int MAX_BIN_US = 1023
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lhp_in_t  in_data,
  output logic     out_valid,
  output lhp_out_t out_data
);

  lhp_cmd_t cmd;
  lhp_sts_t sts;

  lhp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_data.command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  lhp_dp #(
    .MAX_BIN_US (MAX_BIN_US)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  assign out_valid = cmd.emit;

endmodule

>>> rtl/lhp_checker.sv
// ----------------------------------------------------------------------------
// lhp_checker
// Port-level checks on the histogram's command and result beats.
// ----------------------------------------------------------------------------
module lhp_checker import lhp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input lhp_in_t  in_data,
  input logic     out_valid,
  input lhp_out_t out_data
);

  // a result only comes while a query is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("out_valid while idle");

  // one strobe per query, then the block frees up
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result beat not followed by idle");

  // a record beat produces no result while it is in flight
  a_record_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.command == CMD_RECORD))
      |=> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result after record beat");

  // overflow samples are a subset of all samples
  a_ovf_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ovf_count <= out_data.sample_count))
    else $error("overflow count above sample count");

endmodule

bind latency_histogram_percentile lhp_checker u_lhp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

>>> tb/latency_histogram_percentile_tb.sv
// ----------------------------------------------------------------------------
// latency_histogram_percentile_tb
// Self-checking bench for the microsecond latency histogram. Record and query
// beats go in through the start/busy handshake while an in-bench histogram
// mirror predicts every query answer (nearest-rank bin, sample count, overflow
// count), and each out_valid beat is compared field by field.
// ----------------------------------------------------------------------------
module latency_histogram_percentile_tb import lhp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BIN = 1023;

  // Mirror of the histogram plus the queue of answers still owed by the block
  class histogram_scoreboard;
    logic [CNT_W-1:0] bin_tally [MAX_BIN+1];
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] overflow;
    lhp_out_t         answers [$];
    int               errors;
    int               records;
    int               queries;
    int               top_bin;

    function new();
      foreach (bin_tally[i]) bin_tally[i] = '0;
      total    = '0;
      overflow = '0;
      errors   = 0;
      records  = 0;
      queries  = 0;
      top_bin  = 0;
    endfunction

    // saturating +1
    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // ns rounded up to whole us, clamped into the last bin
    function void add_sample(logic [LAT_W-1:0] ns);
      longint unsigned ns_val;
      longint unsigned us;
      int              bin;
      ns_val = ns;
      us     = ns_val / NS_PER_US + (((ns_val % NS_PER_US) != 0) ? 1 : 0);
      bin    = (us > MAX_BIN) ? MAX_BIN : int'(us);
      bin_tally[bin] = bump(bin_tally[bin]);
      total = bump(total);
      if (us >= MAX_BIN) overflow = bump(overflow);
    endfunction

    // nearest rank: first bin whose running sum reaches ceil(q * total)
    function logic [PCT_W-1:0] percentile_at(logic [Q_W-1:0] q);
      longint unsigned qq;
      longint unsigned rank;
      longint unsigned running;
      if (total == '0) return '0;
      qq      = (q > Q_ONE) ? Q_ONE : q;
      rank    = (qq * total + Q_RND) >> Q_FRAC;
      running = 0;
      for (int i = 0; i <= MAX_BIN; i++) begin
        running += bin_tally[i];
        if (running >= rank) return PCT_W'(i);
      end
      return PCT_W'(MAX_BIN);
    endfunction

    function void note_beat(lhp_in_t b);
      lhp_out_t e;
      if (b.command == CMD_RECORD) begin
        add_sample(b.latency_ns);
        records++;
      end else begin
        e.percentile_us = percentile_at(b.quantile);
        e.sample_count  = total;
        e.ovf_count     = overflow;
        answers.insert(answers.size(), e);
        queries++;
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task check_result(lhp_out_t got);
      lhp_out_t want;
      if (answers.size() == 0) begin
        report_mismatch($sformatf("unexpected answer bin %0d count %0d ovf %0d",
                                  got.percentile_us, got.sample_count,
                                  got.ovf_count));
      end else begin
        want = answers.pop_front();
        if (got.percentile_us > top_bin) top_bin = got.percentile_us;
        if (got.percentile_us !== want.percentile_us)
          report_mismatch($sformatf("percentile_us %0d, want %0d",
                                    got.percentile_us, want.percentile_us));
        if (got.sample_count !== want.sample_count)
          report_mismatch($sformatf("sample_count %0d, want %0d",
                                    got.sample_count, want.sample_count));
        if (got.ovf_count !== want.ovf_count)
          report_mismatch($sformatf("ovf_count %0d, want %0d",
                                    got.ovf_count, want.ovf_count));
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  lhp_in_t  in_data = '0;
  logic     out_valid;
  lhp_out_t out_data;

  int sender_idle_pct = 0;

  histogram_scoreboard sb = new();

  latency_histogram_percentile #(.MAX_BIN_US(MAX_BIN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Watch both channels; answers first, since they belong to older beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (start && !busy) sb.note_beat(in_data);
    end
  end

  // Unused fields carry random bits so every input bit toggles
  function lhp_in_t record_beat(logic [LAT_W-1:0] ns);
    lhp_in_t b;
    b.command    = CMD_RECORD;
    b.latency_ns = ns;
    b.quantile   = Q_W'($urandom);
    return b;
  endfunction

  function lhp_in_t query_beat(logic [Q_W-1:0] q);
    lhp_in_t b;
    b.command    = CMD_QUERY;
    b.latency_ns = LAT_W'({$urandom, $urandom});
    b.quantile   = q;
    return b;
  endfunction

  // Latencies: mostly low bins, some across the whole range, rounding edges,
  // full-width values and big powers of two
  function lhp_in_t random_record();
    longint unsigned ns;
    int              sel;
    sel = $urandom_range(9);
    if (sel inside {[0:4]})   ns = $urandom_range(300_000);
    else if (sel inside {5, 6}) ns = $urandom_range(1_100_000);
    else if (sel == 7)        ns = $urandom_range(1, 1100) * 1000 - 1 + $urandom_range(2);
    else if (sel == 8)        ns = {$urandom, $urandom};
    else ns = (64'd1 << $urandom_range(20, 39)) + $urandom_range(2000) - 1000;
    return record_beat(LAT_W'(ns));
  endfunction

  function lhp_in_t random_query();
    logic [Q_W-1:0] q;
    int             sel;
    sel = $urandom_range(9);
    if (sel inside {[0:3]}) q = Q_W'($urandom_range(65536));
    else if (sel == 4)      q = '0;
    else if (sel == 5)      q = Q_ONE;
    else if (sel == 6)      q = Q_W'($urandom_range(65537, 131071));
    else if (sel == 7)      q = Q_W'($urandom_range(1, 64));
    else if (sel == 8)      q = Q_W'($urandom_range(65472, 65535));
    else                    q = Q_W'($urandom_range(131071));
    return query_beat(q);
  endfunction

  // One beat: optional idle gap, then hold start until busy is low at an edge
  task send_beat(lhp_in_t b);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < sender_idle_pct) gap++;
    if (sender_idle_pct > 0 && $urandom_range(19) == 0) gap += $urandom_range(1, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every owed answer has come back
  task drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.answers.size() != 0);
  endtask

  initial begin
    lhp_in_t directed [$];
    int      idle_plan [3];

    idle_plan = '{24, 52, 0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty histogram, rounding edges, top-bin boundary, huge latencies,
    // then quantiles at zero, tiny, just under one, one and above one
    directed = '{
      query_beat(Q_ONE),
      query_beat('0),
      record_beat(40'd0),
      record_beat(40'd1),
      record_beat(40'd1000),
      record_beat(40'd1001),
      record_beat(40'd999),
      record_beat(40'd1_022_000),
      record_beat(40'd1_022_001),
      record_beat(40'd1_023_000),
      record_beat('1),
      record_beat(40'd67_108_863),
      record_beat(40'd67_108_864),
      query_beat('0),
      query_beat(17'd1),
      query_beat(17'd32768),
      query_beat(17'd65535),
      query_beat(Q_ONE),
      query_beat(17'd65537),
      query_beat('1)
    };
    foreach (directed[i]) send_beat(directed[i]);
    drain();

    // random phases with different sender idle rates, settling between them
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_plan[phase];
      repeat (300) begin
        if ($urandom_range(3) == 0) send_beat(random_query());
        else                        send_beat(random_record());
      end
      drain();
    end

    // catch anything arriving late
    repeat (64) @(posedge clk);
    if (sb.answers.size() != 0)
      sb.report_mismatch($sformatf("%0d answers never arrived", sb.answers.size()));

    $display("covered %0d records (%0d reaching the top bin) and %0d percentile queries",
             sb.records, sb.overflow, sb.queries);
    $display("highest bin answered: %0d, mismatches: %0d", sb.top_bin, sb.errors);
    if (sb.errors == 0) begin
      $display("[latency_histogram_percentile] OK");
    end else begin
      $display("[latency_histogram_percentile] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("[latency_histogram_percentile] ERROR");
    $finish;
  end

endmodule
